// ===== hdl/krat_pkg.sv =====
// Shared constants, types and codes of the keyed rating average table
`timescale 1ns / 1ps
package krat_pkg;

  localparam int ENTRIES     = 2048;
  localparam int COUNT_BITS  = 20;
  localparam int ID_W        = 11;
  localparam int RATING_W    = 16;
  localparam int COUNT_OUT_W = 20;
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam int ID_EXT_W    = (ADDR_W > ID_W) ? ADDR_W : ID_W;
  localparam int SUM_W       = RATING_W + COUNT_BITS;
  localparam int QUO_STEPS   = RATING_W;
  localparam int STEP_W      = $clog2(QUO_STEPS + 1);

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [SUM_W-1:0]      sum;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } store_wr_t;

  typedef struct packed {
    logic                  start;
    logic [SUM_W-1:0]      dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [RATING_W-1:0] quotient;
  } div_stat_t;

endpackage

// ===== hdl/krat_store.sv =====
// Entry memory holding count and running sum, one write and one registered read port
`timescale 1ns / 1ps
module krat_store
  import krat_pkg::*;
(
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/krat_div.sv =====
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module krat_div
  import krat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic                  run;
  logic [STEP_W-1:0]     steps;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] divisor;
  logic [QUO_STEPS-1:0]  lo;
  logic                  done;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS+1:0] diff;
  logic                  borrow;

  always_comb begin
    trial  = {rem, lo[QUO_STEPS-1]};
    diff   = {1'b0, trial} - {2'b00, divisor};
    borrow = diff[COUNT_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run     <= 1'b1;
        steps   <= STEP_W'(QUO_STEPS);
        rem     <= req.dividend[SUM_W-1:QUO_STEPS];
        lo      <= req.dividend[QUO_STEPS-1:0];
        divisor <= req.divisor;
      end else if (run) begin
        rem   <= borrow ? trial[COUNT_BITS-1:0] : diff[COUNT_BITS-1:0];
        lo    <= {lo[QUO_STEPS-2:0], ~borrow};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.quotient = lo;

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    req.start |=> run && steps == STEP_W'(QUO_STEPS))
    else $error("divider did not load on start");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(run) && $past(steps) == STEP_W'(1))
    else $error("divider finished early");

endmodule

// ===== hdl/keyed_rating_average_table.sv =====
// Top level: sequencer, clearing pass, entry memory and shared divider
// An accumulate beat is accepted, then does one read-modify-write of the entry memory,
// and gives no result. A read of an empty or out-of-range entry gives its result from
// the lookup state; a read of a filled entry waits for the shared divider, which
// produces one of the 16 quotient bits per cycle. After reset a clearing pass writes
// zeros to all 2048 entries, one per cycle, with busy high. Each result is shown for
// one cycle with done high and must be taken then: the receiver cannot stall it.
`timescale 1ns / 1ps
module keyed_rating_average_table
  import krat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   command,
  input  logic [ID_W-1:0]        entry_id,
  input  logic [RATING_W-1:0]    rating,
  output logic                   done,
  output logic                   found,
  output logic [COUNT_OUT_W-1:0] rating_count,
  output logic [RATING_W-1:0]    average
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_DIV} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic                cmd_q;
  logic                in_table_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [RATING_W-1:0] rating_q;

  logic                accept;
  logic [ID_EXT_W-1:0] id_ext;
  logic                in_table;
  logic [ADDR_W-1:0]   rd_addr;
  entry_t              rd_data;
  store_wr_t           wr;
  div_req_t            dreq;
  div_stat_t           dstat;

  assign busy = (state != S_IDLE);

  always_comb begin
    accept   = start && !busy;
    id_ext   = ID_EXT_W'(entry_id);
    in_table = {1'b0, id_ext} < (ID_EXT_W + 1)'(ENTRIES);
    rd_addr  = id_ext[ADDR_W-1:0];

    wr.en   = 1'b0;
    wr.addr = addr_q;
    wr.data = '0;
    if (state == S_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr;
    end else if (state == S_LOOK && cmd_q == CMD_ACCUMULATE && in_table_q
                 && rd_data.count != COUNT_MAX) begin
      wr.en         = 1'b1;
      wr.data.count = rd_data.count + COUNT_BITS'(1);
      wr.data.sum   = rd_data.sum + SUM_W'(rating_q);
    end

    dreq.start    = (state == S_LOOK) && cmd_q == CMD_READ && in_table_q
                    && rd_data.count != '0;
    dreq.dividend = rd_data.sum;
    dreq.divisor  = rd_data.count;
  end

  krat_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  krat_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .stat (dstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= command;
            in_table_q <= in_table;
            addr_q     <= rd_addr;
            rating_q   <= rating;
            state      <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (cmd_q == CMD_ACCUMULATE) begin
            state <= S_IDLE;
          end else if (dreq.start) begin
            state <= S_DIV;
          end else begin
            done         <= 1'b1;
            found        <= 1'b0;
            rating_count <= '0;
            average      <= '0;
            state        <= S_IDLE;
          end
        end
        S_DIV: begin
          if (dstat.done) begin
            done         <= 1'b1;
            found        <= 1'b1;
            rating_count <= COUNT_OUT_W'(rd_data.count);
            average      <= dstat.quotient;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_LOOK || $past(state) == S_DIV)
    else $error("result beat without a read in progress");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> average == '0 && rating_count == '0)
    else $error("empty result carries data");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_LOOK)
    else $error("accepted beat did not start a lookup");

  a_div_only_read: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> cmd_q == CMD_READ && state == S_LOOK)
    else $error("divider started outside a read");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the keyed rating average table
`timescale 1ns / 1ps
module tb;
  import krat_pkg::*;

  typedef struct packed {
    logic                   found;
    logic [COUNT_OUT_W-1:0] count;
    logic [RATING_W-1:0]    avg;
  } rating_result_t;

  typedef struct packed {
    logic                  cmd;
    logic [ID_W-1:0]       id;
    logic [RATING_W-1:0]   rat;
    logic                  typed;
    rating_result_t        want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   command = CMD_ACCUMULATE;
  logic [ID_W-1:0]        entry_id = '0;
  logic [RATING_W-1:0]    rating = '0;
  logic                   busy;
  logic                   done;
  logic                   found;
  logic [COUNT_OUT_W-1:0] rating_count;
  logic [RATING_W-1:0]    average;

  logic [COUNT_BITS-1:0] tally [ENTRIES];
  logic [SUM_W-1:0]      total [ENTRIES];
  rating_result_t        pending [$];
  int                    fails = 0;

  keyed_rating_average_table DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .entry_id     (entry_id),
    .rating       (rating),
    .done         (done),
    .found        (found),
    .rating_count (rating_count),
    .average      (average)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rating_result_t lookup_average(input logic [ID_W-1:0] id);
    rating_result_t r;
    r = '0;
    if (id < ENTRIES && tally[id] != '0) begin
      r.found = 1'b1;
      r.count = tally[id];
      r.avg   = RATING_W'(total[id] / tally[id]);
    end
    return r;
  endfunction

  function automatic plan_row_t mk_row(input logic cmd, input logic [ID_W-1:0] id,
                                       input logic [RATING_W-1:0] rat, input logic typed,
                                       input logic f, input logic [COUNT_OUT_W-1:0] c,
                                       input logic [RATING_W-1:0] a);
    plan_row_t r;
    r.cmd   = cmd;
    r.id    = id;
    r.rat   = rat;
    r.typed = typed;
    r.want  = {f, c, a};
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic issue_beat(input logic cmd, input logic [ID_W-1:0] id,
                            input logic [RATING_W-1:0] rat, input logic typed,
                            input rating_result_t want);
    rating_result_t exp_r;
    start    <= 1'b1;
    command  <= cmd;
    entry_id <= id;
    rating   <= rat;
    do @(posedge clk); while (busy);
    if (cmd == CMD_READ) begin
      exp_r   = typed ? want : lookup_average(id);
      pending = {pending, exp_r};
    end else if (id < ENTRIES && tally[id] != COUNT_MAX) begin
      tally[id] = tally[id] + COUNT_BITS'(1);
      total[id] = total[id] + SUM_W'(rat);
    end
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    if (pending.size() != 0) begin
      start <= 1'b0;
      while (pending.size() != 0) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : watch_results
    rating_result_t got;
    rating_result_t want;
    if (!rst && done) begin
      got = {found, rating_count, average};
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: found=%0d count=%0d average=%h",
                   got.found, got.count, got.avg);
      end else begin
        want = pending.pop_front();
        if (got.found !== want.found || got.count !== want.count || got.avg !== want.avg) begin
          fails++;
          if (fails <= 10)
            $display({"mismatch: expected found=%0d count=%0d average=%h, ",
                      "got found=%0d count=%0d average=%h"},
                     want.found, want.count, want.avg, got.found, got.count, got.avg);
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t           plan [$];
    plan_row_t           row;
    logic [ID_W-1:0]     hot [16];
    logic [ID_W-1:0]     id;
    logic [RATING_W-1:0] rat;
    logic                cmd;
    int                  burst;

    for (int i = 0; i < ENTRIES; i++) begin
      tally[i] = '0;
      total[i] = '0;
    end

    plan = {plan, mk_row(CMD_READ,       11'd0,    16'h0000, 1'b1, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd2047, 16'hFFFF, 1'b1, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd0,    16'h0000, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd0,    16'h0000, 1'b1, 1'b1, 20'd1, 16'h0000)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd2047, 16'hFFFF, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd2047, 16'h0000, 1'b1, 1'b1, 20'd1, 16'hFFFF)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd2047, 16'hFFFF, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd2047, 16'h0000, 1'b1, 1'b1, 20'd2, 16'hFFFF)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd5,    16'h0001, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd5,    16'h0002, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd5,    16'h0000, 1'b1, 1'b1, 20'd2, 16'h0001)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd5,    16'h0000, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd5,    16'hFFFF, 1'b1, 1'b1, 20'd3, 16'h0001)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd100,  16'h1000, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd100,  16'h3000, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_ACCUMULATE, 11'd100,  16'hABCD, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd100,  16'h0000, 1'b0, 1'b0, 20'd0, 16'h0000)};
    plan = {plan, mk_row(CMD_READ,       11'd1235, 16'h0000, 1'b1, 1'b0, 20'd0, 16'h0000)};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      row = plan[k];
      issue_beat(row.cmd, row.id, row.rat, row.typed, row.want);
      pause_sender(pick_gap());
    end
    drain_results();

    for (int i = 0; i < 16; i++) hot[i] = ID_W'($urandom_range(0, ENTRIES - 1));
    burst = 0;
    for (int n = 0; n < 1200; n++) begin
      if ($urandom_range(0, 9) < 7) id = hot[$urandom_range(0, 15)];
      else id = ID_W'($urandom_range(0, 2**ID_W - 1));
      case ($urandom_range(0, 9))
        0:       rat = '0;
        1:       rat = '1;
        default: rat = RATING_W'($urandom);
      endcase
      cmd = ($urandom_range(0, 99) < 55) ? CMD_ACCUMULATE : CMD_READ;
      issue_beat(cmd, id, rat, 1'b0, '0);
      if (burst > 0) burst--;
      else if ($urandom_range(0, 49) == 0) burst = $urandom_range(20, 80);
      else pause_sender(pick_gap());
      if (n == 600 || $urandom_range(0, 99) == 0) drain_results();
    end

    drain_results();
    start <= 1'b0;
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("keyed_rating_average_table regression: pass");
    end else begin
      $display("keyed_rating_average_table regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("keyed_rating_average_table regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/krat_pkg.sv
hdl/krat_store.sv
hdl/krat_div.sv
hdl/keyed_rating_average_table.sv
dv/tb.sv
